### rtl/ovn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave value noise package
// Shared codes, field widths and the Lanczos-2 kernel samples used by the
// one-dimensional octave value noise block.
// ----------------------------------------------------------------------------
package ovn_pkg;

   localparam int POSITION_W = 32;
   localparam int OCTAVES_W  = 5;
   localparam int INDEX_W    = 9;
   localparam int VALUE_W    = 16;
   localparam int NOISE_W    = 24;
   localparam int WEIGHT_W   = 17;

   localparam logic OP_EVALUATE = 1'b0;
   localparam logic OP_WRITE    = 1'b1;

   localparam logic MODE_LINEAR  = 1'b0;
   localparam logic MODE_LANCZOS = 1'b1;

   localparam int NOISE_MAX = (2 ** (NOISE_W - 1)) - 1;
   localparam int NOISE_MIN = -(2 ** (NOISE_W - 1));

   // Kernel sinc(a) * sinc(a / 2) sampled at a = k / 16, Q1.15.
   localparam int ROM_STEPS = 16;
   localparam int LANCZOS_ROM [0:2*ROM_STEPS] = '{
      32768, 32506, 31727, 30461, 28749, 26651, 24237, 21586,
      18782, 15911, 13058, 10302,  7712,  5348,  3255,  1467,
          0, -1142, -1969, -2503, -2776, -2827, -2698, -2436,
      -2087, -1692, -1291,  -914,  -587,  -326,  -141,   -34,
          0
   };

   typedef logic signed [WEIGHT_W-1:0] weight_type;

endpackage

### rtl/octave_value_noise_1d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave value noise, one dimension
// Sums up to MAX_OCTAVES octaves of periodic value noise over a lattice
// table, with linear or normalised Lanczos-2 four-point blending, and
// returns the saturated sum in signed Q8.16. One shared multiplier is
// sequenced over the table taps of each octave.
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  operation, position, octaves,
//                                            table_index, table_value
// rsp      out        rsp_valid / rsp_ready  noise
// csr      in         csr_write_enable       csr_write_data (interp_mode)
//
// A table write transaction goes from acceptance straight to the final
// step, which loads its result into the output register.
// An evaluate transaction passes through the index, tap and octave steps
// for each octave, paced by the single table read port and the shared
// multiplier visiting each tap in turn.
// The request side is ready only between transactions; the result sits in
// an output register, so a stalled response holds only the final step.
// Reset clears the sequencer and the mode register; the table is undefined
// until written.
// ----------------------------------------------------------------------------
module octave_value_noise_1d #(
   parameter int TABLE_SIZE    = 512,
   parameter int FRACTION_BITS = 24,
   parameter int MAX_OCTAVES   = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_operation,
   input  logic signed [ovn_pkg::POSITION_W-1:0]    req_position,
   input  logic        [ovn_pkg::OCTAVES_W-1:0]     req_octaves,
   input  logic        [ovn_pkg::INDEX_W-1:0]       req_table_index,
   input  logic signed [ovn_pkg::VALUE_W-1:0]       req_table_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [ovn_pkg::NOISE_W-1:0]       rsp_noise,
   input  logic                                     csr_write_enable,
   input  logic                                     csr_write_data
);

   localparam int FB      = FRACTION_BITS;
   localparam int IDX_W   = $clog2(TABLE_SIZE);
   localparam int WIX_W   = (IDX_W + 1 > ovn_pkg::INDEX_W) ? IDX_W + 1 : ovn_pkg::INDEX_W;
   localparam int SUM_W   = IDX_W + 2;
   localparam int PRD_W   = FB + IDX_W + 1;
   localparam int OCT_W   = $clog2(MAX_OCTAVES + 1);
   localparam int BW      = (FB + 1 > ovn_pkg::WEIGHT_W) ? FB + 1 : ovn_pkg::WEIGHT_W;
   localparam int AW      = ovn_pkg::VALUE_W + 1;
   localparam int PW      = AW + BW;
   localparam int ACC_W   = FB + 24;
   localparam int RES_W   = ACC_W - FB + 1;
   localparam int SH_L    = (FB >= 15) ? FB - 15 : 0;
   localparam int SH_R    = (FB >= 15) ? 0 : 15 - FB;
   localparam int WSEL_N  = 2 * ovn_pkg::ROM_STEPS;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_INDEX  = 3'd1;
   localparam logic [2:0] S_TAP    = 3'd2;
   localparam logic [2:0] S_OCT    = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FB - 2);
   localparam logic signed [RES_W-1:0] RES_HI     = RES_W'(ovn_pkg::NOISE_MAX);
   localparam logic signed [RES_W-1:0] RES_LO     = RES_W'(ovn_pkg::NOISE_MIN);

   logic [2:0]                  state_ff, state_in;
   logic                        interp_mode_ff;
   logic [31:0]                 mag_ff, mag_in;
   logic                        neg_ff, neg_in;
   logic [OCT_W-1:0]            n_ff, n_in;
   logic [OCT_W-1:0]            oct_ff, oct_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic signed [FB:0]          t_ff, t_in;
   logic [4:0]                  wsel_ff, wsel_in;
   logic [2:0]                  issue_cnt_ff, issue_cnt_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic [1:0]                  rd_tap_ff, rd_tap_in;
   logic signed [15:0]          rd_data_ff;
   logic signed [15:0]          x1_ff, x1_in;
   logic                        mul_vld_ff, mul_vld_in;
   logic [1:0]                  mul_tap_ff, mul_tap_in;
   logic signed [PW-1:0]        prod_ff, prod_in;
   logic signed [ACC_W-1:0]     term_ff, term_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [ovn_pkg::NOISE_W-1:0] rsp_noise_ff, rsp_noise_in;

   logic signed [15:0]          table_mem [TABLE_SIZE];
   ovn_pkg::weight_type         weight_rom [WSEL_N][4];

   logic [WIX_W-1:0]            wr_index_ext;
   logic                        mem_we;
   logic [IDX_W-1:0]            wr_addr;
   logic [OCT_W-1:0]            n_clamp;
   logic [ovn_pkg::OCTAVES_W-1:0] oct_req;
   logic [PRD_W-1:0]            lattice_prd;
   logic [FB-1:0]               u_val;
   logic                        tneg;
   logic [2:0]                  last_tap;
   logic                        issuing;
   logic [SUM_W-1:0]            addr_sum;
   logic [IDX_W-1:0]            rd_addr;
   logic signed [AW-1:0]        mul_a;
   logic signed [BW-1:0]        mul_b;
   logic signed [ACC_W-1:0]     conv;
   logic signed [ACC_W-1:0]     scaled;
   logic signed [ACC_W-1:0]     rounded;
   logic signed [RES_W-1:0]     res;
   logic signed [RES_W-1:0]     sat;

   // Normalised kernel weights, one row per sign of t and quantised u.
   for (genvar g = 0; g < WSEL_N; g++) begin : g_wrow
      for (genvar j = 0; j < 4; j++) begin : g_wcol
         localparam int  Q  = g % ovn_pkg::ROM_STEPS;
         localparam bit  TN = (g >= ovn_pkg::ROM_STEPS);
         localparam int  R0 = TN ? ovn_pkg::LANCZOS_ROM[ovn_pkg::ROM_STEPS - Q]
                                 : ovn_pkg::LANCZOS_ROM[ovn_pkg::ROM_STEPS + Q];
         localparam int  R1 = ovn_pkg::LANCZOS_ROM[Q];
         localparam int  R2 = TN ? ovn_pkg::LANCZOS_ROM[ovn_pkg::ROM_STEPS + Q]
                                 : ovn_pkg::LANCZOS_ROM[ovn_pkg::ROM_STEPS - Q];
         localparam int  R3 = TN ? 0 : ovn_pkg::LANCZOS_ROM[2 * ovn_pkg::ROM_STEPS - Q];
         localparam int  RAW = (j == 0) ? R0 : (j == 1) ? R1 : (j == 2) ? R2 : R3;
         localparam int  RSUM = R0 + R1 + R2 + R3;
         localparam longint SUM_K = (RSUM <= 0) ? 64'sd1 : longint'(RSUM);
         localparam longint MAG_K = longint'((RAW < 0) ? -RAW : RAW) * 64'sd32768;
         localparam longint WMAG  = (MAG_K + SUM_K / 2) / SUM_K;
         localparam longint WGT   = (RAW < 0) ? -WMAG : WMAG;
         assign weight_rom[g][j] = ovn_pkg::WEIGHT_W'(WGT);
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_noise = rsp_noise_ff;

   assign wr_index_ext = WIX_W'(req_table_index);
   assign wr_addr      = wr_index_ext[IDX_W-1:0];
   assign mem_we       = req_valid && req_ready && (req_operation == ovn_pkg::OP_WRITE)
                         && (wr_index_ext < WIX_W'(TABLE_SIZE));

   assign oct_req = (req_octaves > ovn_pkg::OCTAVES_W'(MAX_OCTAVES))
                    ? ovn_pkg::OCTAVES_W'(MAX_OCTAVES) : req_octaves;
   assign n_clamp = OCT_W'(oct_req);

   assign lattice_prd = PRD_W'(mag_ff[FB-1:0]) * PRD_W'(TABLE_SIZE);
   assign u_val       = lattice_prd[FB-1:0];
   assign tneg        = neg_ff && (u_val != '0);

   assign last_tap = (interp_mode_ff == ovn_pkg::MODE_LANCZOS) ? 3'd3 : 3'd2;
   assign issuing  = (state_ff == S_TAP) && (issue_cnt_ff <= last_tap);

   // Tap k addresses entry idx + k - 1, wrapped around the table.
   assign addr_sum = SUM_W'(idx_ff) + SUM_W'(TABLE_SIZE - 1) + SUM_W'(issue_cnt_ff[1:0]);

   always_comb begin
      if (addr_sum >= SUM_W'(2 * TABLE_SIZE)) begin
         rd_addr = IDX_W'(addr_sum - SUM_W'(2 * TABLE_SIZE));
      end else if (addr_sum >= SUM_W'(TABLE_SIZE)) begin
         rd_addr = IDX_W'(addr_sum - SUM_W'(TABLE_SIZE));
      end else begin
         rd_addr = IDX_W'(addr_sum);
      end
   end

   assign mul_a = (interp_mode_ff == ovn_pkg::MODE_LANCZOS)
                  ? AW'(rd_data_ff) : AW'(rd_data_ff) - AW'(x1_ff);
   assign mul_b = (interp_mode_ff == ovn_pkg::MODE_LANCZOS)
                  ? BW'(weight_rom[wsel_ff][rd_tap_ff]) : BW'(t_ff);
   assign prod_in = PW'(mul_a) * PW'(mul_b);

   always_comb begin
      if (interp_mode_ff == ovn_pkg::MODE_LINEAR) begin
         conv = term_ff;
      end else if (FB >= 15) begin
         conv = term_ff <<< SH_L;
      end else begin
         conv = term_ff >>> SH_R;
      end
   end

   assign scaled  = conv >>> oct_ff;
   assign rounded = acc_ff + ROUND_HALF;
   assign res     = RES_W'(rounded >>> (FB - 1));

   always_comb begin
      if (res > RES_HI) begin
         sat = RES_HI;
      end else if (res < RES_LO) begin
         sat = RES_LO;
      end else begin
         sat = res;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      n_in         = n_ff;
      oct_in       = oct_ff;
      idx_in       = idx_ff;
      t_in         = t_ff;
      wsel_in      = wsel_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_vld_in    = issuing;
      rd_tap_in    = issue_cnt_ff[1:0];
      x1_in        = x1_ff;
      mul_vld_in   = 1'b0;
      mul_tap_in   = rd_tap_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_noise_in = rsp_noise_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               acc_in = '0;
               oct_in = '0;
               n_in   = n_clamp;
               neg_in = req_position[ovn_pkg::POSITION_W-1];
               mag_in = req_position[ovn_pkg::POSITION_W-1]
                        ? 32'(-req_position) : 32'(req_position);
               if ((req_operation == ovn_pkg::OP_WRITE) || (n_clamp == '0)) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_INDEX;
               end
            end
         end
         S_INDEX: begin
            idx_in       = lattice_prd[FB +: IDX_W];
            t_in         = tneg ? -$signed({1'b0, u_val}) : $signed({1'b0, u_val});
            wsel_in      = {tneg, u_val[FB-1 -: 4]};
            issue_cnt_in = (interp_mode_ff == ovn_pkg::MODE_LANCZOS) ? 3'd0 : 3'd1;
            term_in      = '0;
            state_in     = S_TAP;
         end
         S_TAP: begin
            if (issuing) begin
               issue_cnt_in = issue_cnt_ff + 3'd1;
            end
            if (rd_vld_ff) begin
               if ((interp_mode_ff == ovn_pkg::MODE_LINEAR) && (rd_tap_ff == 2'd1)) begin
                  x1_in   = rd_data_ff;
                  term_in = ACC_W'(rd_data_ff) <<< FB;
               end else begin
                  mul_vld_in = 1'b1;
               end
            end
            if (mul_vld_ff) begin
               term_in = term_ff + ACC_W'(prod_ff);
               if (mul_tap_ff == last_tap[1:0]) begin
                  state_in = S_OCT;
               end
            end
         end
         S_OCT: begin
            acc_in = acc_ff + scaled;
            mag_in = mag_ff >> 1;
            oct_in = oct_ff + OCT_W'(1);
            if (oct_ff == n_ff - OCT_W'(1)) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_INDEX;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_noise_in = ovn_pkg::NOISE_W'(sat);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[wr_addr] <= req_table_value;
      end
      if (issuing) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         interp_mode_ff <= ovn_pkg::MODE_LINEAR;
         rd_vld_ff      <= 1'b0;
         mul_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         mul_vld_ff   <= mul_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            interp_mode_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      n_ff         <= n_in;
      oct_ff       <= oct_in;
      idx_ff       <= idx_in;
      t_ff         <= t_in;
      wsel_ff      <= wsel_in;
      issue_cnt_ff <= issue_cnt_in;
      rd_tap_ff    <= rd_tap_in;
      x1_ff        <= x1_in;
      mul_tap_ff   <= mul_tap_in;
      prod_ff      <= prod_in;
      term_ff      <= term_in;
      acc_ff       <= acc_in;
      rsp_noise_ff <= rsp_noise_in;
   end

   // A response is only ever loaded by the final step of a transaction.
   a_rsp_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside the final step");

   // The octave counter never runs past the requested count.
   a_oct_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (oct_ff <= n_ff))
      else $error("octave counter beyond requested count");

   // The tap pipeline has drained when an octave is folded into the sum.
   a_pipe_drained : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OCT) |-> (!rd_vld_ff && !mul_vld_ff))
      else $error("tap pipeline busy at octave accumulation");

   // Products only arrive while the taps of an octave are being processed.
   a_mul_in_tap : assert property (@(posedge clock) disable iff (reset)
      mul_vld_ff |-> (state_ff == S_TAP))
      else $error("product valid outside tap processing");

endmodule
